[rtl/rpnc_pkg.sv]
// Shared types and constants for the RPN stack calculator.
// No dependencies; used by rpnc_alu and rpn_stack_calculator.
package rpnc_pkg;

   localparam int DATA_W        = 32;
   localparam int ACT_W         = 3;
   localparam int STATUS_W      = 2;
   localparam int DEPTH_OUT_W   = 8;
   localparam int STACK_DEPTH_D = 128;

   // command codes
   localparam logic [ACT_W-1:0] ACT_PUSH = 3'd0;
   localparam logic [ACT_W-1:0] ACT_ADD  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_SUB  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_MUL  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DIV  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_PEEK = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP_A,
      S_GET_A,
      S_POP_B,
      S_GET_B,
      S_EXEC,
      S_WAIT,
      S_STORE,
      S_REPLY
   } ctl_state_type;

   typedef enum logic [2:0] {
      A_IDLE,
      A_ONE,
      A_MUL,
      A_ABS_A,
      A_ABS_B,
      A_DIV,
      A_FIX,
      A_DONE
   } alu_phase_type;

   typedef struct packed {
      logic              start;
      logic [ACT_W-1:0]  op;
      logic [DATA_W-1:0] opa;   // top of stack
      logic [DATA_W-1:0] opb;   // next entry
   } alu_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } alu_rsp_type;

endpackage

[rtl/rpnc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rpnc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rpnc_alu.sv]
// Iterative arithmetic unit: one 33-bit adder shared by add, subtract,
// shift-add multiply and restoring divide. Depends on rpnc_pkg.
module rpnc_alu
   import rpnc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   localparam int CNT_W = $clog2(DATA_W);
   localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(DATA_W - 1);

   alu_phase_type     phase_ff, phase_in;
   logic [ACT_W-1:0]  op_ff, op_in;
   logic [DATA_W-1:0] opa_ff, opa_in;
   logic [DATA_W-1:0] opb_ff, opb_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;

   // shared adder
   logic [DATA_W:0] add_x;
   logic [DATA_W:0] add_y;
   logic            add_sub;
   logic [DATA_W:0] add_sum;

   assign add_sum = add_x + (add_sub ? ~add_y : add_y) + {{DATA_W{1'b0}}, add_sub};

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         A_IDLE: begin
            if (req.start) begin
               unique case (req.op) inside
                  ACT_ADD, ACT_SUB: phase_in = A_ONE;
                  ACT_MUL:          phase_in = A_MUL;
                  ACT_DIV:          phase_in = A_ABS_A;
                  default:          phase_in = A_DONE;
               endcase
            end
         end
         A_ONE:   phase_in = A_DONE;
         A_MUL:   phase_in = (cnt_ff == ITER_LAST) ? A_DONE : A_MUL;
         A_ABS_A: phase_in = A_ABS_B;
         A_ABS_B: phase_in = A_DIV;
         A_DIV:   phase_in = (cnt_ff == ITER_LAST) ? A_FIX : A_DIV;
         A_FIX:   phase_in = A_DONE;
         A_DONE:  phase_in = A_IDLE;
         default: phase_in = A_IDLE;
      endcase
   end

   always_comb begin
      op_in   = op_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      add_x   = {1'b0, opb_ff};
      add_y   = {1'b0, opa_ff};
      add_sub = 1'b0;
      unique case (phase_ff)
         A_IDLE: begin
            if (req.start) begin
               op_in  = req.op;
               opa_in = req.opa;
               opb_in = req.opb;
               acc_in = '0;
               cnt_in = '0;
               neg_in = req.opa[DATA_W-1] ^ req.opb[DATA_W-1];
            end
         end
         A_ONE: begin
            add_sub = (op_ff == ACT_SUB);
            acc_in  = add_sum[DATA_W-1:0];
         end
         A_MUL: begin
            // opa shifts right as the multiplier, opb left as the multiplicand
            add_x  = {1'b0, acc_ff};
            add_y  = {1'b0, opb_ff};
            if (opa_ff[0]) begin
               acc_in = add_sum[DATA_W-1:0];
            end
            opa_in = {1'b0, opa_ff[DATA_W-1:1]};
            opb_in = {opb_ff[DATA_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
         end
         A_ABS_A: begin
            add_x   = '0;
            add_y   = {1'b0, opa_ff};
            add_sub = 1'b1;
            if (opa_ff[DATA_W-1]) begin
               opa_in = add_sum[DATA_W-1:0];
            end
         end
         A_ABS_B: begin
            add_x   = '0;
            add_y   = {1'b0, opb_ff};
            add_sub = 1'b1;
            if (opb_ff[DATA_W-1]) begin
               opb_in = add_sum[DATA_W-1:0];
            end
            acc_in = '0;
         end
         A_DIV: begin
            // restoring step: acc is the remainder, opb shifts in quotient bits
            add_x   = {acc_ff, opb_ff[DATA_W-1]};
            add_y   = {1'b0, opa_ff};
            add_sub = 1'b1;
            if (add_sum[DATA_W]) begin
               acc_in = add_x[DATA_W-1:0];
            end else begin
               acc_in = add_sum[DATA_W-1:0];
            end
            opb_in = {opb_ff[DATA_W-2:0], ~add_sum[DATA_W]};
            cnt_in = cnt_ff + 1'b1;
         end
         A_FIX: begin
            add_x   = '0;
            add_y   = {1'b0, opb_ff};
            add_sub = 1'b1;
            acc_in  = neg_ff ? add_sum[DATA_W-1:0] : opb_ff;
         end
         A_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= A_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      op_ff  <= op_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign rsp.done   = (phase_ff == A_DONE);
   assign rsp.result = acc_ff;

endmodule

[rtl/rpn_stack_calculator.sv]
// RPN stack calculator top level: command sequencer, operand stack and
// result register. Depends on rpnc_pkg, rpnc_ram and rpnc_alu.
//
//   req_valid/req_stall carry one command (req_action, req_operand) per
//   transfer. rsp_valid/rsp_stall return exactly one result per command
//   (rsp_result_value, rsp_status, rsp_depth_after).
//   One command is in flight at a time; req_stall stays high from the
//   transfer until its result is loaded into the output register, and the
//   next command can transfer in the cycle after that load, even while that result waits.
//   Push, peek, invalid codes and divide by zero bypass rpnc_alu.
//   Multiply and divide run 32 iterations of the shared adder in rpnc_alu and
//   set the command rate: a divide keeps req_stall high until its result
//   is loaded.
//   Pops read the stack RAM through its registered read port.
//   Reset (synchronous) empties the stack and drops any pending result;
//   the stack contents need no clearing since only written entries are read.
//   If the receiver stalls, the result holds and the sequencer waits in
//   its reply step before loading the next result.
module rpn_stack_calculator
   import rpnc_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_D
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ACT_W-1:0]           req_action,
   input  logic signed [DATA_W-1:0]   req_operand,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [DATA_W-1:0]   rsp_result_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [DEPTH_OUT_W-1:0]     rsp_depth_after
);

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

   ctl_state_type     state_ff, state_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              hit_ff, hit_in;
   logic              under_ff, under_in;
   logic              divz_ff, divz_in;
   logic              full_ff, full_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [DEPTH_OUT_W-1:0]  rsp_depth_ff, rsp_depth_in;

   logic                    req_xfer;
   logic                    rsp_free;
   logic                    cnt_empty;
   logic                    cnt_room;
   logic [ADDR_W-1:0]       top_addr;
   logic [CNT_W+DEPTH_OUT_W-1:0] depth_ext;

   logic                    ram_wr_en;
   logic                    ram_rd_en;
   logic [DATA_W-1:0]       ram_rd_data;
   logic [DATA_W-1:0]       pop_value;

   alu_req_type             alu_req;
   alu_rsp_type             alu_rsp;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_empty = (cnt_ff == '0);
   assign cnt_room  = (cnt_ff < CNT_FULL);
   assign top_addr  = ADDR_W'(cnt_ff - CNT_W'(1));
   assign depth_ext = {{DEPTH_OUT_W{1'b0}}, cnt_ff};
   assign pop_value = hit_ff ? ram_rd_data : '0;

   rpnc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (res_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (top_addr),
      .rd_data (ram_rd_data)
   );

   rpnc_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               unique case (req_action) inside
                  ACT_PUSH:                                   state_in = S_STORE;
                  ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_PEEK: state_in = S_POP_A;
                  default:                                    state_in = S_REPLY;
               endcase
            end
         end
         S_POP_A: state_in = S_GET_A;
         S_GET_A: state_in = (act_ff == ACT_PEEK) ? S_STORE : S_POP_B;
         S_POP_B: state_in = S_GET_B;
         S_GET_B: begin
            if (act_ff == ACT_DIV && a_ff == '0) begin
               state_in = S_REPLY;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC:  state_in = S_WAIT;
         S_WAIT:  state_in = alu_rsp.done ? S_STORE : S_WAIT;
         S_STORE: state_in = S_REPLY;
         S_REPLY: state_in = rsp_free ? S_IDLE : S_REPLY;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      act_in        = act_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      res_in        = res_ff;
      cnt_in        = cnt_ff;
      hit_in        = hit_ff;
      under_in      = under_ff;
      divz_in       = divz_ff;
      full_in       = full_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      alu_req.start = 1'b0;
      alu_req.op    = act_ff;
      alu_req.opa   = a_ff;
      alu_req.opb   = b_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in  = rsp_depth_ff;

      unique case (state_ff) inside
         S_IDLE: begin
            if (req_xfer) begin
               act_in   = req_action;
               res_in   = (req_action == ACT_PUSH) ? req_operand : '0;
               under_in = 1'b0;
               divz_in  = 1'b0;
               full_in  = 1'b0;
            end
         end
         S_POP_A, S_POP_B: begin
            // an empty stack pops as zero and stays empty
            hit_in = !cnt_empty;
            if (cnt_empty) begin
               under_in = 1'b1;
            end else begin
               ram_rd_en = 1'b1;
               cnt_in    = cnt_ff - CNT_W'(1);
            end
         end
         S_GET_A: begin
            a_in   = pop_value;
            res_in = pop_value;
         end
         S_GET_B: begin
            b_in = pop_value;
            if (act_ff == ACT_DIV && a_ff == '0) begin
               divz_in = 1'b1;
               res_in  = '0;
            end
         end
         S_EXEC: begin
            alu_req.start = 1'b1;
         end
         S_WAIT: begin
            if (alu_rsp.done) begin
               res_in = alu_rsp.result;
            end
         end
         S_STORE: begin
            if (cnt_room) begin
               ram_wr_en = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
            end else begin
               full_in = 1'b1;
            end
         end
         S_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_depth_in = depth_ext[DEPTH_OUT_W-1:0];
               if (under_ff) begin
                  rsp_status_in = ST_UNDER;
               end else if (divz_ff) begin
                  rsp_status_in = ST_DIVZ;
               end else if (full_ff) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  rsp_status_in = ST_OK;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff        <= act_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      res_ff        <= res_in;
      hit_ff        <= hit_in;
      under_ff      <= under_in;
      divz_ff       <= divz_in;
      full_ff       <= full_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_depth_after  = rsp_depth_ff;

endmodule

[test/tb_top.sv]
// Self-checking testbench for rpn_stack_calculator: random command streams,
// a predicting scoreboard and random stalls. Depends on rpnc_pkg and the RTL.
`timescale 1ns / 100ps

import rpnc_pkg::*;

typedef struct {
   logic [DATA_W-1:0]      value;
   logic [STATUS_W-1:0]    status;
   logic [DEPTH_OUT_W-1:0] depth;
} calc_result_type;

class calc_scoreboard;
   logic [DATA_W-1:0] operand_stack [STACK_DEPTH_D];
   int unsigned       stack_fill;
   calc_result_type   due_results [$];
   int unsigned       errors;

   function new();
      stack_fill = 0;
      errors     = 0;
   endfunction

   function logic [DATA_W-1:0] pop_top(inout logic under);
      if (stack_fill == 0) begin
         under = 1'b1;
         return '0;
      end
      stack_fill--;
      return operand_stack[stack_fill];
   endfunction

   function logic push_value(input logic [DATA_W-1:0] v);
      if (stack_fill >= STACK_DEPTH_D) return 1'b0;
      operand_stack[stack_fill] = v;
      stack_fill++;
      return 1'b1;
   endfunction

   // predict the response of one transferred command
   function void note_command(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] opnd);
      logic [DATA_W-1:0] a, b, res;
      logic [STATUS_W-1:0] st;
      logic under, keep;
      calc_result_type r;
      res   = '0;
      st    = ST_OK;
      under = 1'b0;
      keep  = 1'b1;
      case (act) inside
         ACT_PUSH: begin
            res = opnd;
            if (!push_value(opnd)) st = ST_FULL;
         end
         ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
            a = pop_top(under);
            b = pop_top(under);
            case (act)
               ACT_ADD: res = b + a;
               ACT_SUB: res = b - a;
               ACT_MUL: res = b * a;
               default: begin
                  if (a == '0) begin
                     keep = 1'b0;
                     st   = ST_DIVZ;
                  end else if (b == 32'h8000_0000 && a == '1) begin
                     res = 32'h8000_0000;   // wraps
                  end else begin
                     res = $signed(b) / $signed(a);
                  end
               end
            endcase
            if (keep) void'(push_value(res));
            if (under) st = ST_UNDER;
         end
         ACT_PEEK: begin
            res = pop_top(under);
            void'(push_value(res));
            if (under) st = ST_UNDER;
         end
         default: ;   // unused codes leave everything alone
      endcase
      r.value  = res;
      r.status = st;
      r.depth  = DEPTH_OUT_W'(stack_fill);
      due_results.push_back(r);
   endfunction

   function void check_result(input logic [DATA_W-1:0] value,
                              input logic [STATUS_W-1:0] status,
                              input logic [DEPTH_OUT_W-1:0] depth);
      calc_result_type want;
      if (due_results.size() == 0) begin
         errors++;
         $display("%0t: response with nothing due: value %h status %0d depth %0d",
                  $time, value, status, depth);
         return;
      end
      want = due_results.pop_front();
      if (value !== want.value) begin
         errors++;
         $display("%0t: result_value expected %h actual %h", $time, want.value, value);
      end
      if (status !== want.status) begin
         errors++;
         $display("%0t: status expected %0d actual %0d", $time, want.status, status);
      end
      if (depth !== want.depth) begin
         errors++;
         $display("%0t: depth_after expected %0d actual %0d", $time, want.depth, depth);
      end
   endfunction

   function int unsigned pending();
      return due_results.size();
   endfunction
endclass

module tb_top;

   localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd6;
   localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;
   localparam int unsigned      RANDOM_ITEMS  = 1325;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [ACT_W-1:0]         req_action;
   logic signed [DATA_W-1:0] req_operand;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_result_value;
   logic [STATUS_W-1:0]      rsp_status;
   logic [DEPTH_OUT_W-1:0]   rsp_depth_after;

   calc_scoreboard sb;
   int unsigned    burst_left = 0;
   int unsigned    stall_cycle = 0;
   logic [1:0]     stall_mode = 2'd0;

   rpn_stack_calculator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_operand      (req_operand),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_depth_after  (rsp_depth_after)
   );

   always #5 clock = ~clock;

   // receiver: stalls follow a randomly re-picked mode: none, sparse, dense or periodic
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 256 == 0) stall_mode <= 2'($urandom_range(0, 3));
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         case (stall_mode)
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((stall_cycle % 7) < 3);
         endcase
      end
   end

   // response check before command capture: a response never belongs to
   // a command transferred on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_result_value, rsp_status, rsp_depth_after);
         if (req_valid && !req_stall)
            sb.note_command(req_action, req_operand);
      end
   end

   initial begin
      #8_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [DATA_W-1:0] pick_operand();
      logic [DATA_W-1:0] near_zero;
      near_zero = $urandom_range(0, 16);
      case ($urandom_range(0, 9)) inside
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '1;
         3: return '0;
         4, 5: return near_zero - 32'd8;
         default: return $urandom();
      endcase
   endfunction

   // sender works in bursts with random gaps in between
   task automatic issue_command(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] opnd);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_action  <= act;
      req_operand <= opnd;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      int unsigned sent;
      int unsigned phase_len;
      int unsigned push_pct;
      int unsigned roll;
      sb = new();
      sent = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_action  <= ACT_PUSH;
      req_operand <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-stack pops, wrap cases, division corners, unused codes
      issue_command(ACT_PEEK, 32'h1234_5678);
      issue_command(ACT_DIV, '0);
      issue_command(ACT_PUSH, 32'h7fff_ffff);
      issue_command(ACT_PUSH, 32'h8000_0000);
      issue_command(ACT_ADD, '0);
      issue_command(ACT_PUSH, 32'd1);
      issue_command(ACT_SUB, '1);
      issue_command(ACT_PUSH, 32'h8000_0000);
      issue_command(ACT_PUSH, '1);
      issue_command(ACT_DIV, '0);
      issue_command(ACT_PUSH, 32'd7);
      issue_command(ACT_PUSH, -32'sd2);
      issue_command(ACT_DIV, '0);
      issue_command(ACT_PUSH, -32'sd7);
      issue_command(ACT_PUSH, 32'd2);
      issue_command(ACT_DIV, '0);
      issue_command(ACT_PUSH, 32'd5);
      issue_command(ACT_PUSH, '0);
      issue_command(ACT_DIV, '0);
      issue_command(ACT_PUSH, 32'h7fff_ffff);
      issue_command(ACT_PUSH, 32'd2);
      issue_command(ACT_MUL, '0);
      issue_command(ACT_PEEK, '0);
      issue_command(ACT_UNUSED_LO, 32'hffff_ffff);
      issue_command(ACT_UNUSED_HI, 32'h0000_0000);
      drain_results();

      // random phases: fill-heavy ones hit the full stack, pop-heavy ones underflow
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(40, 220);
         case ($urandom_range(0, 2))
            0: push_pct = 90;
            1: push_pct = 50;
            default: push_pct = 20;
         endcase
         repeat (phase_len) begin
            if (sent >= RANDOM_ITEMS) break;
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
               issue_command(($urandom_range(0, 1) != 0) ? ACT_UNUSED_LO : ACT_UNUSED_HI,
                             pick_operand());
               sent++;
            end else if (roll < 5) begin
               issue_command(ACT_PUSH, 32'h8000_0000);
               issue_command(ACT_PUSH, '1);
               issue_command(ACT_DIV, pick_operand());
               sent += 3;
            end else if ($urandom_range(0, 99) < push_pct) begin
               issue_command(ACT_PUSH, pick_operand());
               sent++;
            end else begin
               case ($urandom_range(0, 4))
                  0: issue_command(ACT_ADD, pick_operand());
                  1: issue_command(ACT_SUB, pick_operand());
                  2: issue_command(ACT_MUL, pick_operand());
                  3: issue_command(ACT_DIV, pick_operand());
                  default: issue_command(ACT_PEEK, pick_operand());
               endcase
               sent++;
            end
         end
         if ($urandom_range(0, 2) == 0) drain_results();
      end

      drain_results();
      repeat (60) @(posedge clock);   // catch any stray response
      if (sb.errors == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
